// ===== sv/wcm_pkg.sv =====
// Shared constants, command type and helpers for the wall column texture mapper.
package wcm_pkg;

    localparam int TEX_W    = 64;
    localparam int TEX_H    = 64;
    localparam int SCREEN_W = 640;
    localparam int SCREEN_H = 480;

    localparam int TEXELS   = TEX_W * TEX_H;
    localparam int SLOTS    = 4;
    localparam int MEM_DEPTH = SLOTS * TEXELS;
    localparam int MEM_AW   = $clog2(MEM_DEPTH);
    localparam int IDX_W    = $clog2(TEXELS);
    localparam int COL_W    = $clog2(TEX_W);
    localparam int TY_W     = $clog2(TEX_H);
    localparam int POS_W    = TY_W + 16;
    localparam int QUO_W    = TY_W + 17;
    localparam int COLOR_W  = 24;
    localparam int LH_W     = 15;
    localparam int BASE_W   = LH_W + 1;
    localparam int ROW_W    = 10;
    localparam int FRAC_W   = 16;
    localparam int TIDX_W   = 12;
    localparam int PIX_AW   = 19;

    localparam logic [COLOR_W-1:0] DARK_MASK = 24'h7F7F7F;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_PIXEL = 2'd2;

    localparam logic [1:0] SLOT_N = 2'd0;
    localparam logic [1:0] SLOT_S = 2'd1;
    localparam logic [1:0] SLOT_E = 2'd2;
    localparam logic [1:0] SLOT_W = 2'd3;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_START,
        OP_PIXEL
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic [MEM_AW-1:0]        wr_addr;
        logic [COLOR_W-1:0]       color;
        logic [1:0]               slot;
        logic [COL_W-1:0]         tex_col;
        logic                     dark;
        logic [LH_W-1:0]          lh;
        logic signed [BASE_W-1:0] base;
        logic [ROW_W-1:0]         row_first;
        logic [ROW_W-1:0]         row_end;
        logic [ROW_W-1:0]         column;
    } t_cmd;

    function automatic logic [MEM_AW-1:0] tex_addr(input logic [1:0] slot,
                                                   input logic [IDX_W-1:0] idx);
        tex_addr = MEM_AW'(slot) * MEM_AW'(TEXELS) + MEM_AW'(idx);
    endfunction

endpackage

// ===== sv/wcm_front.sv =====
// Front end: accept words, decode the action and precompute column setup values.
module wcm_front
    import wcm_pkg::*;
(
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_action,
    input  logic [1:0]          i_texture_slot,
    input  logic [TIDX_W-1:0]   i_texel_index,
    input  logic [COLOR_W-1:0]  i_texel_color,
    input  logic [FRAC_W-1:0]   i_wall_frac,
    input  logic                i_hit_side,
    input  logic                i_ray_positive,
    input  logic [LH_W-1:0]     i_line_height,
    input  logic [ROW_W-1:0]    i_draw_start,
    input  logic [ROW_W-1:0]    i_draw_end,
    input  logic [ROW_W-1:0]    i_column,
    input  logic                i_q_full,
    output logic                o_push,
    output t_cmd                o_cmd
);

    localparam int TXP_W = FRAC_W + $clog2(TEX_W + 1);
    localparam int TX_W  = TXP_W - FRAC_W;

    logic              keep;
    logic [TXP_W-1:0]  tx_prod;
    logic [TX_W-1:0]   tx;
    logic [LH_W-1:0]   lh;

    always_comb begin
        tx_prod = TXP_W'(i_wall_frac) * TXP_W'(TEX_W);
        tx      = tx_prod[TXP_W-1:FRAC_W];
        if (tx > TX_W'(TEX_W - 1)) begin
            tx = TX_W'(TEX_W - 1);
        end
        lh = (i_line_height == '0) ? LH_W'(1) : i_line_height;
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.wr_addr   = tex_addr(i_texture_slot, IDX_W'(i_texel_index));
        o_cmd.color     = i_texel_color;
        o_cmd.tex_col   = COL_W'(TX_W'(TEX_W - 1) - tx);
        o_cmd.dark      = i_hit_side;
        o_cmd.lh        = lh;
        o_cmd.base      = BASE_W'(i_draw_start) - BASE_W'(SCREEN_H / 2)
                        + BASE_W'(lh >> 1);
        o_cmd.row_first = i_draw_start;
        o_cmd.row_end   = i_draw_end;
        o_cmd.column    = i_column;
        if (i_hit_side == 1'b0) begin
            o_cmd.slot = i_ray_positive ? SLOT_N : SLOT_S;
        end else begin
            o_cmd.slot = i_ray_positive ? SLOT_W : SLOT_E;
        end
        keep     = 1'b0;
        o_cmd.op = OP_PIXEL;
        unique case (i_action)
            ACT_WRITE: begin
                o_cmd.op = OP_WRITE;
                // drop writes past the end of one texture
                keep     = 32'(i_texel_index) < 32'(TEXELS);
            end
            ACT_START: begin
                o_cmd.op = OP_START;
                keep     = 1'b1;
            end
            ACT_PIXEL: begin
                o_cmd.op = OP_PIXEL;
                keep     = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full && keep;

endmodule

// ===== sv/wcm_queue.sv =====
// Short command queue between the front end and the back end.
module wcm_queue
    import wcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_cmd          r_q [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          do_pop;

    assign o_full  = r_cnt == (AW + 1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_q[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW + 1)'(i_push) - (AW + 1)'(do_pop);
        end
    end

endmodule

// ===== sv/wcm_div.sv =====
// Bit-serial restoring divider for the vertical texture step.
module wcm_div
    import wcm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [LH_W-1:0]  i_divisor,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [QUO_W-1:0] DIVIDEND = QUO_W'(TEX_H) << 16;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [LH_W-1:0]  r_rem;
    logic [LH_W-1:0]  r_dvs;
    logic [QUO_W-1:0] r_quo;
    logic [LH_W:0]    trial;
    logic [LH_W:0]    diff;
    logic             ge;

    always_comb begin
        trial = {r_rem, DIVIDEND[r_cnt]};
        diff  = trial - {1'b0, r_dvs};
        ge    = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_dvs  <= '0;
            r_quo  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W - 1);
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? diff[LH_W-1:0] : trial[LH_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sv/wcm_back.sv =====
// Back end: texture store, column setup and the pixel read and output pipeline.
module wcm_back
    import wcm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIX_AW-1:0]  o_pixel_address,
    output logic [COLOR_W-1:0] o_pixel_color,
    output logic               o_last_pixel
);

    typedef enum logic {
        ST_EXEC,
        ST_DIV
    } t_state;

    t_state                   r_state;
    logic [COLOR_W-1:0]       r_tex_mem [MEM_DEPTH];
    logic [COLOR_W-1:0]       r_rd_data;

    logic [POS_W-1:0]         r_pos;
    logic [POS_W-1:0]         r_step;
    logic [COL_W-1:0]         r_col;
    logic [1:0]               r_slot;
    logic                     r_dark;
    logic [ROW_W-1:0]         r_row;
    logic [ROW_W-1:0]         r_end;
    logic [ROW_W-1:0]         r_column;
    logic signed [BASE_W-1:0] r_base;

    logic                     r_s1_valid;
    logic [PIX_AW-1:0]        r_s1_addr;
    logic                     r_s1_last;
    logic                     r_s1_dark;

    logic                     r_out_valid;
    logic [PIX_AW-1:0]        r_out_addr;
    logic [COLOR_W-1:0]       r_out_color;
    logic                     r_out_last;

    logic                     mem_we;
    logic                     issue;
    logic                     div_start;
    logic                     div_done;
    logic [QUO_W-1:0]         div_quo;
    logic                     span_active;
    logic                     s1_move;
    logic                     issue_ok;
    logic [TY_W-1:0]          ty;
    logic [IDX_W:0]           idx_sum;
    logic [IDX_W-1:0]         idx;
    logic [MEM_AW-1:0]        rd_addr;
    logic [PIX_AW-1:0]        pix_addr;
    logic [POS_W-1:0]         base_ext;
    logic [2*POS_W-1:0]       pos_prod;

    wcm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (i_cmd.lh),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        span_active = r_row < r_end;
        s1_move     = r_s1_valid && (!r_out_valid || i_ready);
        issue_ok    = !r_s1_valid || s1_move;

        ty      = r_pos[POS_W-1:16];
        idx_sum = (IDX_W + 1)'(ty) * (IDX_W + 1)'(TEX_H) + (IDX_W + 1)'(r_col);
        if (idx_sum >= (IDX_W + 1)'(TEXELS)) begin
            idx_sum = idx_sum - (IDX_W + 1)'(TEXELS);
        end
        idx      = idx_sum[IDX_W-1:0];
        rd_addr  = tex_addr(r_slot, idx);
        pix_addr = PIX_AW'(r_row) * PIX_AW'(SCREEN_W) + PIX_AW'(r_column);

        // low bits of the start position only need the low bits of each factor
        base_ext = POS_W'(r_base);
        pos_prod = (2 * POS_W)'(base_ext) * (2 * POS_W)'(div_quo[POS_W-1:0]);

        o_pop     = 1'b0;
        mem_we    = 1'b0;
        issue     = 1'b0;
        div_start = 1'b0;
        if (i_q_valid && r_state == ST_EXEC) begin
            unique case (i_cmd.op)
                OP_WRITE: begin
                    o_pop  = 1'b1;
                    mem_we = 1'b1;
                end
                OP_START: begin
                    o_pop     = 1'b1;
                    div_start = 1'b1;
                end
                OP_PIXEL: begin
                    if (!span_active) begin
                        o_pop = 1'b1;
                    end else if (issue_ok) begin
                        o_pop = 1'b1;
                        issue = 1'b1;
                    end
                end
                default: begin
                    o_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tex_mem[i_cmd.wr_addr] <= i_cmd.color;
        end
        if (issue) begin
            r_rd_data <= r_tex_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_EXEC;
            r_pos       <= '0;
            r_step      <= '0;
            r_col       <= '0;
            r_slot      <= '0;
            r_dark      <= 1'b0;
            r_row       <= '0;
            r_end       <= '0;
            r_column    <= '0;
            r_base      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_EXEC: begin
                    if (div_start) begin
                        r_slot   <= i_cmd.slot;
                        r_col    <= i_cmd.tex_col;
                        r_dark   <= i_cmd.dark;
                        r_row    <= i_cmd.row_first;
                        r_end    <= i_cmd.row_end;
                        r_column <= i_cmd.column;
                        r_base   <= i_cmd.base;
                        r_state  <= ST_DIV;
                    end
                    if (issue) begin
                        r_pos     <= r_pos + r_step;
                        r_row     <= r_row + ROW_W'(1);
                        r_s1_addr <= pix_addr;
                        r_s1_last <= (r_row + ROW_W'(1)) == r_end;
                        r_s1_dark <= r_dark;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_step  <= div_quo[POS_W-1:0];
                        r_pos   <= pos_prod[POS_W-1:0];
                        r_state <= ST_EXEC;
                    end
                end
                default: begin
                    r_state <= ST_EXEC;
                end
            endcase

            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_move) begin
                r_out_valid <= 1'b1;
                r_out_addr  <= r_s1_addr;
                r_out_last  <= r_s1_last;
                r_out_color <= r_s1_dark ? ((r_rd_data >> 1) & DARK_MASK) : r_rd_data;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pixel_address = r_out_addr;
    assign o_pixel_color   = r_out_color;
    assign o_last_pixel    = r_out_last;

endmodule

// ===== sv/wall_column_texture_mapper.sv =====
// Top level of the textured wall column renderer for a grid raycaster.
// Each input word carries one action. Write texel (action 0) stores one 24-bit
// texel into one of four 64x64 textures (N, S, E, W); indexes past the texture
// are dropped. Start column (action 1) picks the texture from hit side and ray
// sign, mirrors the texture column from the hit fraction, and computes the
// Q16.16 step TEX_H/line_height and the start position; a line height of zero
// counts as one. Emit pixel (action 2) yields one output word with the
// framebuffer address row*SCREEN_W+column (19 bits), the texel color, halved
// per channel on y-side hits, and a last flag on the final row of the span; on
// an empty or finished span it yields nothing. Action 3 is accepted and ignored.
// Timing: texel writes and pixels run one word per cycle sustained while no
// column start or output backpressure holds the back end. A column start holds
// the back end while the bit-serial step divider runs, one quotient bit per
// cycle; words keep being taken into a four-entry command queue meanwhile. A
// pixel leaving the queue passes the texture read register, then the output
// register. The texture store is not cleared at reset; reading a texel never
// written gives an undefined color. Texture memory: 16384 x 24 bits, one write
// and one registered read port.
module wall_column_texture_mapper
    import wcm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic [1:0]         i_texture_slot,
    input  logic [TIDX_W-1:0]  i_texel_index,
    input  logic [COLOR_W-1:0] i_texel_color,
    input  logic [FRAC_W-1:0]  i_wall_frac,
    input  logic               i_hit_side,
    input  logic               i_ray_positive,
    input  logic [LH_W-1:0]    i_line_height,
    input  logic [ROW_W-1:0]   i_draw_start,
    input  logic [ROW_W-1:0]   i_draw_end,
    input  logic [ROW_W-1:0]   i_column,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIX_AW-1:0]  o_pixel_address,
    output logic [COLOR_W-1:0] o_pixel_color,
    output logic               o_last_pixel
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_cmd front_cmd;
    t_cmd head_cmd;

    // decode and precompute; push only words that do something
    wcm_front u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_texture_slot (i_texture_slot),
        .i_texel_index  (i_texel_index),
        .i_texel_color  (i_texel_color),
        .i_wall_frac    (i_wall_frac),
        .i_hit_side     (i_hit_side),
        .i_ray_positive (i_ray_positive),
        .i_line_height  (i_line_height),
        .i_draw_start   (i_draw_start),
        .i_draw_end     (i_draw_end),
        .i_column       (i_column),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_cmd          (front_cmd)
    );

    // decouple intake from the divider stall and output backpressure
    wcm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // execute commands in order; pixels flow through read and output stages
    wcm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_cmd           (head_cmd),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_last_pixel    (o_last_pixel)
    );

endmodule

// ===== tb/wall_column_texture_mapper_test.sv =====
// Self-checking testbench for the wall column texture mapper.
module wall_column_texture_mapper_test;
    timeunit 1ns;
    timeprecision 1ps;
    import wcm_pkg::*;

    // Action 3 has no name in the package; the block takes it and does nothing.
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_REPORTS     = 40;
    localparam int RANDOM_WORDS    = 220;
    localparam int STEADY_WORDS    = 50;

    // One input word, all fields at port widths.
    typedef struct packed {
        logic [1:0]         action;
        logic [1:0]         slot;
        logic [TIDX_W-1:0]  tidx;
        logic [COLOR_W-1:0] tcolor;
        logic [FRAC_W-1:0]  frac;
        logic               side;
        logic               raypos;
        logic [LH_W-1:0]    lh;
        logic [ROW_W-1:0]   ds;
        logic [ROW_W-1:0]   de;
        logic [ROW_W-1:0]   col;
    } t_mapper_word;

    // One framebuffer pixel as the block should emit it.
    typedef struct packed {
        logic [PIX_AW-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_pixel;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_valid         = 1'b0;
    logic               o_ready;
    logic [1:0]         i_action        = ACT_NONE;
    logic [1:0]         i_texture_slot  = '0;
    logic [TIDX_W-1:0]  i_texel_index   = '0;
    logic [COLOR_W-1:0] i_texel_color   = '0;
    logic [FRAC_W-1:0]  i_wall_frac     = '0;
    logic               i_hit_side      = 1'b0;
    logic               i_ray_positive  = 1'b0;
    logic [LH_W-1:0]    i_line_height   = '0;
    logic [ROW_W-1:0]   i_draw_start    = '0;
    logic [ROW_W-1:0]   i_draw_end      = '0;
    logic [ROW_W-1:0]   i_column        = '0;
    logic               o_valid;
    logic               i_ready         = 1'b0;
    logic [PIX_AW-1:0]  o_pixel_address;
    logic [COLOR_W-1:0] o_pixel_color;
    logic               o_last_pixel;

    // Run control used by the stimulus, the sink, the checker and the watchdog.
    bit          idle_on       = 1'b1;
    bit          hold_off_req  = 1'b0;
    int unsigned error_count   = 0;
    int unsigned quiet_cycles  = 0;

    // Predicted pixels, oldest first.
    t_pixel expected_pixels[$];

    // Shadow copy of the mapper: texture memory and column walker state.
    logic [COLOR_W-1:0] tex_mem [MEM_DEPTH];
    logic [31:0]        pos_q    = '0;
    logic [31:0]        step_q   = '0;
    logic [COL_W-1:0]   tcol     = '0;
    logic [1:0]         slot_sel = SLOT_N;
    logic               dark     = 1'b0;
    logic [ROW_W-1:0]   row_now  = '0;
    logic [ROW_W-1:0]   row_stop = '0;
    logic [ROW_W-1:0]   col_now  = '0;

    wall_column_texture_mapper u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_texture_slot  (i_texture_slot),
        .i_texel_index   (i_texel_index),
        .i_texel_color   (i_texel_color),
        .i_wall_frac     (i_wall_frac),
        .i_hit_side      (i_hit_side),
        .i_ray_positive  (i_ray_positive),
        .i_line_height   (i_line_height),
        .i_draw_start    (i_draw_start),
        .i_draw_end      (i_draw_end),
        .i_column        (i_column),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_last_pixel    (o_last_pixel)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endfunction

    // Fill every field at random; callers then pin the fields that matter.
    function automatic t_mapper_word random_word();
        t_mapper_word w;
        w.action = 2'($urandom_range(0, 3));
        w.slot   = 2'($urandom);
        w.tidx   = TIDX_W'($urandom);
        w.tcolor = COLOR_W'($urandom);
        w.frac   = FRAC_W'($urandom);
        w.side   = 1'($urandom);
        w.raypos = 1'($urandom);
        w.lh     = LH_W'($urandom);
        w.ds     = ROW_W'($urandom);
        w.de     = ROW_W'($urandom);
        w.col    = ROW_W'($urandom);
        return w;
    endfunction

    // Advance the shadow mapper by one accepted word and queue any pixel it yields.
    task automatic advance_mapper(input t_mapper_word w, output bit made);
        int unsigned lh_eff;
        int unsigned tx;
        int unsigned ty;
        int unsigned idx;
        int unsigned addr;
        longint      base;
        t_pixel      px;
        made = 1'b0;
        case (w.action)
            ACT_WRITE: begin
                if (w.tidx < TEXELS)
                    tex_mem[int'(w.slot) * TEXELS + int'(w.tidx)] = w.tcolor;
            end
            ACT_START: begin
                // A zero line height counts as one.
                lh_eff = (w.lh == 0) ? 1 : int'(w.lh);
                if (w.side)
                    slot_sel = w.raypos ? SLOT_W : SLOT_E;
                else
                    slot_sel = w.raypos ? SLOT_N : SLOT_S;
                // Mirror the texture column taken from the hit fraction.
                tx = (int'(w.frac) * TEX_W) >> 16;
                if (tx > TEX_W - 1)
                    tx = TEX_W - 1;
                tcol   = COL_W'(TEX_W - 1 - tx);
                step_q = (32'(TEX_H) << 16) / lh_eff;
                // Start position may be negative; keep its two's complement bits.
                base   = longint'(w.ds) - longint'(SCREEN_H / 2) + longint'(lh_eff / 2);
                pos_q  = 32'(base * longint'(step_q));
                dark     = w.side;
                row_now  = w.ds;
                row_stop = w.de;
                col_now  = w.col;
            end
            ACT_PIXEL: begin
                // Empty or finished span: nothing comes out.
                if (row_now < row_stop) begin
                    ty    = (pos_q >> 16) & (TEX_H - 1);
                    pos_q = pos_q + step_q;
                    idx   = (ty * TEX_H + tcol) % TEXELS;
                    px.color = tex_mem[int'(slot_sel) * TEXELS + idx];
                    if (dark)
                        px.color = (px.color >> 1) & DARK_MASK;
                    // Rows past the screen wrap the address to its port width.
                    addr    = int'(row_now) * SCREEN_W + int'(col_now);
                    px.addr = PIX_AW'(addr);
                    px.last = (int'(row_now) + 1 == int'(row_stop));
                    row_now = row_now + 1'b1;
                    expected_pixels.push_back(px);
                    made = 1'b1;
                end
            end
            default: begin
            end
        endcase
    endtask

    // Offer one word, maybe after an idle burst, and hold it until it is taken.
    task automatic send_word(input t_mapper_word w, output bit made);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= w.action;
        i_texture_slot <= w.slot;
        i_texel_index  <= w.tidx;
        i_texel_color  <= w.tcolor;
        i_wall_frac    <= w.frac;
        i_hit_side     <= w.side;
        i_ray_positive <= w.raypos;
        i_line_height  <= w.lh;
        i_draw_start   <= w.ds;
        i_draw_end     <= w.de;
        i_column       <= w.col;
        do @(posedge i_clk); while (!o_ready);
        advance_mapper(w, made);
    endtask

    task automatic start_column(input logic [FRAC_W-1:0] frac, input logic side,
                                input logic raypos, input logic [LH_W-1:0] lh,
                                input logic [ROW_W-1:0] ds, input logic [ROW_W-1:0] de,
                                input logic [ROW_W-1:0] col);
        t_mapper_word w;
        bit           made;
        w        = random_word();
        w.action = ACT_START;
        w.frac   = frac;
        w.side   = side;
        w.raypos = raypos;
        w.lh     = lh;
        w.ds     = ds;
        w.de     = de;
        w.col    = col;
        send_word(w, made);
    endtask

    // Send n pixel ticks with junk in the unused fields; count those that yield.
    task automatic send_pixels(input int unsigned n, output int unsigned made_count);
        t_mapper_word w;
        bit           made;
        made_count = 0;
        repeat (n) begin
            w        = random_word();
            w.action = ACT_PIXEL;
            send_word(w, made);
            if (made)
                made_count++;
        end
    endtask

    // Mostly well-formed columns (start, then a span of ticks), plus texel
    // writes and noise; stop once enough words have done real work.
    // Fractions stay on the loaded texture column, or on the first texel when
    // the line is one pixel tall, so no tick reads an unwritten texel.
    task automatic run_column_sequences(input int unsigned target);
        int unsigned  done_words;
        int unsigned  pick;
        int unsigned  span;
        int unsigned  ticks;
        int unsigned  made_count;
        bit           made;
        t_mapper_word w;
        done_words = 0;
        while (done_words < target) begin
            pick = $urandom_range(0, 99);
            w    = random_word();
            if (pick < 70) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    w.lh = LH_W'($urandom_range(1, 512));
                else if (pick == 9) begin
                    case ($urandom_range(0, 2))
                        0:       w.lh = '0;
                        1:       w.lh = LH_W'(1);
                        default: w.lh = '1;
                    endcase
                end
                if (w.lh <= LH_W'(1) && $urandom_range(0, 1) == 0)
                    w.frac = FRAC_W'($urandom_range(16'hFC00, 16'hFFFF));
                else
                    w.frac = FRAC_W'($urandom_range(0, 16'h03FF));
                // Short spans keep results dense; now and then the span is free.
                if ($urandom_range(0, 9) != 0) begin
                    w.ds = ROW_W'($urandom_range(0, 1010));
                    w.de = w.ds + ROW_W'($urandom_range(1, 12));
                end
                start_column(w.frac, w.side, w.raypos, w.lh, w.ds, w.de, w.col);
                done_words++;
                span = (w.de > w.ds) ? int'(w.de) - int'(w.ds) : 0;
                if (span > 16)
                    span = 16;
                ticks = span + $urandom_range(0, 2);
                // Sometimes cut the column short and restart mid-span.
                if ($urandom_range(0, 7) == 0)
                    ticks = $urandom_range(0, ticks);
                send_pixels(ticks, made_count);
                done_words += made_count;
            end else if (pick < 85) begin
                w.action = ACT_WRITE;
                send_word(w, made);
                done_words++;
            end else begin
                w.action = $urandom_range(0, 1) ? ACT_NONE : ACT_PIXEL;
                send_word(w, made);
                if (made)
                    done_words++;
            end
        end
    endtask

    // Load the last column of every texture, which low fractions sample, and
    // the first texel, which a one-pixel-tall line with a full fraction samples.
    task automatic test_texture_load();
        t_mapper_word w;
        bit           made;
        for (int s = 0; s < SLOTS; s++) begin
            w        = random_word();
            w.action = ACT_WRITE;
            w.slot   = 2'(s);
            w.tidx   = '0;
            w.tcolor = '0;
            send_word(w, made);
            for (int r = 0; r < TEX_H; r++) begin
                w        = random_word();
                w.action = ACT_WRITE;
                w.slot   = 2'(s);
                w.tidx   = TIDX_W'(r * TEX_H + (TEX_W - 1));
                if (r == TEX_H - 1)
                    w.tcolor = '1;
                send_word(w, made);
            end
        end
    endtask

    task automatic test_directed();
        t_mapper_word w;
        bit           made;
        int unsigned  made_count;
        // No span yet after reset: the tick yields nothing.
        send_pixels(1, made_count);
        w        = random_word();
        w.action = ACT_NONE;
        send_word(w, made);
        // North texture, zero fraction, unit step from position zero, then one tick too many.
        start_column(16'h0000, 1'b0, 1'b1, 15'd64, 10'd208, 10'd211, 10'd0);
        send_pixels(4, made_count);
        // South texture, full fraction, zero height as one, negative start position.
        start_column(16'hFFFF, 1'b0, 1'b0, 15'd0, 10'd0, 10'd2, 10'd1023);
        send_pixels(2, made_count);
        // West texture darkened, tallest line, rows past the screen wrap the address.
        start_column(16'h0200, 1'b1, 1'b1, 15'd32767, 10'd1020, 10'd1023, 10'd1023);
        send_pixels(3, made_count);
        // East texture, empty span where start equals end.
        start_column(16'h03FF, 1'b1, 1'b0, 15'd1, 10'd500, 10'd500, 10'd17);
        send_pixels(1, made_count);
        // Start past end: still empty.
        start_column(16'h0400, 1'b1, 1'b1, 15'd3, 10'd10, 10'd5, 10'd5);
        send_pixels(1, made_count);
    endtask

    // Stall the sink for a long stretch while ticks keep coming, filling the block.
    task automatic test_backpressure();
        int unsigned made_count;
        start_column(16'h0123, 1'b0, 1'b1, 15'd64, 10'd100, 10'd160, 10'd320);
        hold_off_req = 1'b1;
        send_pixels(60, made_count);
    endtask

    task automatic test_random_columns();
        run_column_sequences(RANDOM_WORDS);
    endtask

    // Final stretch at full rate on both sides.
    task automatic test_steady_stream();
        idle_on = 1'b0;
        run_column_sequences(STEADY_WORDS);
    endtask

    // Pixel sink: random stall bursts, plus one long hold-off on request.
    initial begin : pixel_sink
        int unsigned n;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
                i_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Compare each taken pixel with the oldest prediction.
    always @(posedge i_clk) begin : check_pixels
        t_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pixels.size() == 0) begin
                report_error($sformatf("unexpected pixel: address %h color %h last %b",
                                       o_pixel_address, o_pixel_color, o_last_pixel));
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_address !== want.addr)
                    report_error($sformatf("pixel_address: expected %h, got %h",
                                           want.addr, o_pixel_address));
                if (o_pixel_color !== want.color)
                    report_error($sformatf("pixel_color: expected %h, got %h",
                                           want.color, o_pixel_color));
                if (o_last_pixel !== want.last)
                    report_error($sformatf("last_pixel: expected %b, got %b",
                                           want.last, o_last_pixel));
            end
        end
    end

    // End the run if neither side moves a word for too long.
    always @(posedge i_clk) begin : watchdog
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_texture_load();
        test_directed();
        test_backpressure();
        test_random_columns();
        test_steady_stream();
        i_valid <= 1'b0;
        // Drain what is still in flight, then give stray pixels time to show.
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
sv/wcm_pkg.sv
sv/wcm_front.sv
sv/wcm_queue.sv
sv/wcm_div.sv
sv/wcm_back.sv
sv/wall_column_texture_mapper.sv
tb/wall_column_texture_mapper_test.sv
